/* rtl/tphc_pkg.sv */
// tphc_pkg: shared types, constants and the end-around fold for the
// transport pseudo-header checksum core. Used by all modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tphc_pkg;

    localparam int MAX_SEGMENT_BYTES_DEF = 65535;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DESTINATION_ADDRESS = 2'd2;

    typedef enum logic [1:0] {
        MODE_TCP  = 2'd0,
        MODE_UDP  = 2'd1,
        MODE_ICMP = 2'd2
    } t_mode;

    localparam logic [15:0] PROTO_NUM_TCP = 16'd6;
    localparam logic [15:0] PROTO_NUM_UDP = 16'd17;

    localparam logic [4:0] OFFSET_TCP_CHECK  = 5'd16;
    localparam logic [4:0] OFFSET_UDP_CHECK  = 5'd6;
    localparam logic [4:0] OFFSET_ICMP_CHECK = 5'd2;

    // configuration view handed to the datapath
    typedef struct packed {
        logic [4:0]  chk_off;
        logic [15:0] pseudo_sum;
        logic        pseudo_en;
    } t_cfg;

    // a finished segment waiting for the pseudo-header add
    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] len;
        logic        ovf;
    } t_fin;

    // ones' complement fold of up to five 16-bit terms
    function automatic logic [15:0] fold16(input logic [18:0] v);
        logic [16:0] t1;
        t1 = 17'(v[15:0]) + 17'(v[18:16]);
        return t1[15:0] + 16'(t1[16]);
    endfunction

endpackage

`default_nettype wire

/* rtl/tphc_in_if.sv */
// tphc_in_if: valid/ready channel carrying segment bytes.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface tphc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] segment_byte;
    logic       final_byte;

    modport source (output valid, output segment_byte, output final_byte, input ready);
    modport sink   (input valid, input segment_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* rtl/tphc_out_if.sv */
// tphc_out_if: valid/ready channel carrying checksum results.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface tphc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum_value;
    logic [15:0] segment_length;
    logic        length_overflow;

    modport source (output valid, output checksum_value, output segment_length,
                    output length_overflow, input ready);
    modport sink   (input valid, input checksum_value, input segment_length,
                    input length_overflow, output ready);
endinterface

`default_nettype wire

/* rtl/transport_pseudo_header_checksum_core.sv */
// Internet checksum of one TCP, UDP or ICMP segment, fed a byte per beat,
// with the IPv4 pseudo-header added for TCP and UDP.
//
// Channels: i_seg (sink) carries segment_byte and final_byte; o_res
// (source) carries checksum_value, segment_length and length_overflow,
// one result per beat marked final. A beat moves when valid and ready are
// both high. Configuration goes through i_cfg_wr_en / i_cfg_index /
// i_cfg_data: 0 protocol mode, 1 source address, 2 destination address;
// write it only while no segment is in flight.
// Throughput: one byte per cycle while i_seg.ready is high; the end-around
// add of a byte pair into the running sum loops through one register. Path:
// the edge that accepts the final byte puts the sum in the finished-segment
// register, then the pseudo-header add goes into the output register.
// Stall: a result holds in the output register; one more finished segment
// waits behind it, and i_seg.ready drops only when both are full.
// Reset (synchronous, active low): control registers to zero, mode TCP,
// no segment in progress; the block takes bytes once reset ends.
// Depends on tphc_pkg, tphc_in_if, tphc_out_if and the tphc_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module transport_pseudo_header_checksum_core #(
    parameter int MAX_SEGMENT_BYTES = tphc_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [tphc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tphc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tphc_in_if.sink                              i_seg,
    tphc_out_if.source                           o_res
);

    tphc_pkg::t_cfg cfg;
    tphc_pkg::t_fin fin;
    logic           fin_valid;
    logic           fin_take;
    logic           accept;

    // a new beat fits whenever the finished-segment slot is free or draining
    assign i_seg.ready = !fin_valid || fin_take;
    assign accept      = i_seg.valid && i_seg.ready;

    tphc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tphc_accum #(
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (i_seg.segment_byte),
        .i_final     (i_seg.final_byte),
        .i_fin_take  (fin_take),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    tphc_finish #(
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_take  (fin_take),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

/* rtl/tphc_cfg_regs.sv */
// tphc_cfg_regs: configuration registers and the precomputed constant
// part of the pseudo-header sum. Depends on tphc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tphc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [tphc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tphc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tphc_pkg::t_cfg                      o_cfg
);

    logic [1:0]  r_mode;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [15:0] r_pseudo, n_pseudo;
    logic        pseudo_en;
    logic [15:0] proto;
    logic [18:0] raw_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_src  <= 32'd0;
            r_dst  <= 32'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tphc_pkg::REG_PROTOCOL_MODE:       r_mode <= i_cfg_data[1:0];
                tphc_pkg::REG_SOURCE_ADDRESS:      r_src  <= i_cfg_data;
                tphc_pkg::REG_DESTINATION_ADDRESS: r_dst  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pseudo_en = (r_mode == tphc_pkg::MODE_TCP) || (r_mode == tphc_pkg::MODE_UDP);
        proto     = (r_mode == tphc_pkg::MODE_TCP) ? tphc_pkg::PROTO_NUM_TCP
                                                   : tphc_pkg::PROTO_NUM_UDP;
        raw_sum   = 19'(r_src[31:16]) + 19'(r_src[15:0]) + 19'(r_dst[31:16])
                  + 19'(r_dst[15:0]) + 19'(proto);
        n_pseudo  = tphc_pkg::fold16(raw_sum);
    end

    // address part only matters at the end of a segment, so registering it is fine
    always_ff @(posedge i_clk) begin
        r_pseudo <= n_pseudo;
    end

    always_comb begin
        case (r_mode)
            tphc_pkg::MODE_TCP: o_cfg.chk_off = tphc_pkg::OFFSET_TCP_CHECK;
            tphc_pkg::MODE_UDP: o_cfg.chk_off = tphc_pkg::OFFSET_UDP_CHECK;
            default:            o_cfg.chk_off = tphc_pkg::OFFSET_ICMP_CHECK;
        endcase
        o_cfg.pseudo_sum = r_pseudo;
        o_cfg.pseudo_en  = pseudo_en;
    end

endmodule

`default_nettype wire

/* rtl/tphc_accum.sv */
// tphc_accum: per-beat word assembly, running ones' complement sum and
// byte count; hands each finished segment to the finish stage. Depends on tphc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tphc_accum #(
    parameter int MAX_SEGMENT_BYTES = tphc_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  tphc_pkg::t_cfg      i_cfg,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_final,
    input  wire logic           i_fin_take,
    output logic                o_fin_valid,
    output tphc_pkg::t_fin      o_fin
);

    localparam int CW    = $clog2(MAX_SEGMENT_BYTES + 2);
    localparam int CMP_W = (CW > 5) ? CW : 5;

    logic [15:0]       r_sum, n_sum;
    logic [7:0]        r_held, n_held;
    logic              r_odd, n_odd;
    logic [CW-1:0]     r_count, n_count, cnt_inc;
    logic              r_fin_valid, n_fin_valid;
    tphc_pkg::t_fin    r_fin, n_fin;
    logic [CMP_W-1:0]  cnt_ext, off_ext;
    logic [7:0]        b_eff;
    logic [15:0]       word, sum_w;
    logic              ovf;

    always_comb begin
        cnt_ext = CMP_W'(r_count);
        off_ext = CMP_W'(i_cfg.chk_off);
        // the segment's own checksum field counts as zero
        b_eff   = ((cnt_ext == off_ext) || (cnt_ext == off_ext + CMP_W'(1))) ? 8'h00 : i_byte;
        // an even byte that ends the segment is padded low with zero
        word    = r_odd ? {r_held, b_eff} : {b_eff, 8'h00};
        sum_w   = tphc_pkg::fold16(19'(r_sum) + 19'(word));
        cnt_inc = (r_count <= CW'(MAX_SEGMENT_BYTES)) ? r_count + CW'(1) : r_count;
        ovf     = cnt_inc > CW'(MAX_SEGMENT_BYTES);

        n_sum       = r_sum;
        n_held      = r_held;
        n_odd       = r_odd;
        n_count     = r_count;
        n_fin       = r_fin;
        n_fin_valid = r_fin_valid && !i_fin_take;

        if (i_accept) begin
            if (i_final) begin
                n_sum       = 16'd0;
                n_held      = 8'd0;
                n_odd       = 1'b0;
                n_count     = '0;
                n_fin_valid = 1'b1;
                n_fin.sum   = sum_w;
                n_fin.ovf   = ovf;
                n_fin.len   = ovf ? 16'(MAX_SEGMENT_BYTES) : 16'(cnt_inc);
            end else begin
                n_count = cnt_inc;
                if (r_odd) begin
                    n_sum  = sum_w;
                    n_held = 8'd0;
                    n_odd  = 1'b0;
                end else begin
                    n_held = b_eff;
                    n_odd  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 16'd0;
            r_held      <= 8'd0;
            r_odd       <= 1'b0;
            r_count     <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_held      <= n_held;
            r_odd       <= n_odd;
            r_count     <= n_count;
            r_fin_valid <= n_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENT_BYTES + 1))
        else $error("byte count past saturation");

    a_held_clear_when_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_odd |-> (r_held == 8'd0))
        else $error("held byte left over at even position");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_final) |=> (r_count == '0) && (r_sum == 16'd0) && !r_odd && r_fin_valid)
        else $error("segment state not cleared after final beat");

endmodule

`default_nettype wire

/* rtl/tphc_finish.sv */
// tphc_finish: adds pseudo-header and length for TCP/UDP, inverts, and holds
// the result in the output register. Depends on tphc_pkg and tphc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tphc_finish #(
    parameter int MAX_SEGMENT_BYTES = tphc_pkg::MAX_SEGMENT_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  tphc_pkg::t_cfg     i_cfg,
    input  wire logic          i_fin_valid,
    input  tphc_pkg::t_fin     i_fin,
    output logic               o_fin_take,
    tphc_out_if.source         o_res
);

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_chk, n_chk;
    logic [15:0] r_len;
    logic        r_ovf;
    logic [18:0] total;

    always_comb begin
        o_fin_take  = i_fin_valid && (!r_out_valid || o_res.ready);
        total       = i_cfg.pseudo_en
                    ? 19'(i_fin.sum) + 19'(i_cfg.pseudo_sum) + 19'(i_fin.len)
                    : 19'(i_fin.sum);
        n_chk       = ~tphc_pkg::fold16(total);
        n_out_valid = o_fin_take || (r_out_valid && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_take) begin
            r_chk <= n_chk;
            r_len <= i_fin.len;
            r_ovf <= i_fin.ovf;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.checksum_value  = r_chk;
    assign o_res.segment_length  = r_len;
    assign o_res.length_overflow = r_ovf;

    a_fin_waits_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fin_valid && r_out_valid && !o_res.ready) |-> !o_fin_take)
        else $error("finished segment taken over a stalled result");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |-> (r_len == 16'(MAX_SEGMENT_BYTES)))
        else $error("overflowed length not saturated");

endmodule

`default_nettype wire

/* verif/transport_pseudo_header_checksum_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for transport_pseudo_header_checksum_core: segments go in byte by
// byte; each result is checked against a predicted ones' complement sum (header in tcp/udp).
// Depends on tphc_pkg, tphc_in_if, tphc_out_if and the core itself.

module transport_pseudo_header_checksum_core_test;
    import tphc_pkg::*;

    localparam int SEG_LIMIT       = MAX_SEGMENT_BYTES_DEF;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PRESSURE_CYCLES = 400;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0]           MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] length;
        logic        overflow;
    } csum_result_t;

    class checksum_scoreboard;
        logic [1:0]   mode;
        logic [31:0]  src_addr;
        logic [31:0]  dst_addr;
        logic [15:0]  sum;
        logic [16:0]  count;
        logic [7:0]   high_byte;
        bit           odd;
        csum_result_t pending_checksums[$];
        int           errors;

        function new();
            mode     = MODE_TCP;
            src_addr = '0;
            dst_addr = '0;
            errors   = 0;
            clear_segment();
        endfunction

        function void clear_segment();
            sum       = '0;
            count     = '0;
            high_byte = '0;
            odd       = 1'b0;
        endfunction

        function logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
            case (idx)
                REG_PROTOCOL_MODE:       mode = data[1:0];
                REG_SOURCE_ADDRESS:      src_addr = data;
                REG_DESTINATION_ADDRESS: dst_addr = data;
                default: ;
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input logic fin);
            logic [4:0]   off;
            logic [7:0]   v;
            logic [15:0]  total;
            csum_result_t r;
            off = (mode == MODE_TCP) ? OFFSET_TCP_CHECK :
                  (mode == MODE_UDP) ? OFFSET_UDP_CHECK : OFFSET_ICMP_CHECK;
            v = b;
            // the segment's own checksum field counts as zero
            if (count == 17'(off) || count == 17'(off) + 17'd1)
                v = '0;
            if (odd) begin
                sum       = ones_add(sum, {high_byte, v});
                high_byte = '0;
                odd       = 1'b0;
            end else begin
                high_byte = v;
                odd       = 1'b1;
            end
            if (count <= 17'(SEG_LIMIT))
                count++;
            if (fin) begin
                total = sum;
                // odd trailing byte is padded low with zero
                if (odd)
                    total = ones_add(total, {high_byte, 8'h00});
                r.overflow = (count > 17'(SEG_LIMIT));
                r.length   = r.overflow ? 16'(SEG_LIMIT) : count[15:0];
                if (mode == MODE_TCP || mode == MODE_UDP) begin
                    total = ones_add(total, src_addr[31:16]);
                    total = ones_add(total, src_addr[15:0]);
                    total = ones_add(total, dst_addr[31:16]);
                    total = ones_add(total, dst_addr[15:0]);
                    total = ones_add(total, (mode == MODE_TCP) ? PROTO_NUM_TCP : PROTO_NUM_UDP);
                    total = ones_add(total, r.length);
                end
                r.checksum = ~total;
                pending_checksums.push_back(r);
                clear_segment();
            end
        endfunction

        function void compare_result(input logic [15:0] csum, input logic [15:0] len,
                                     input logic ovf);
            csum_result_t e;
            if (pending_checksums.size() == 0) begin
                errors++;
                $error("unexpected result beat: checksum_value %h", csum);
                return;
            end
            e = pending_checksums.pop_front();
            if (csum !== e.checksum) begin
                errors++;
                $error("checksum_value: expected %h, got %h", e.checksum, csum);
            end
            if (len !== e.length) begin
                errors++;
                $error("segment_length: expected %0d, got %0d", e.length, len);
            end
            if (ovf !== e.overflow) begin
                errors++;
                $error("length_overflow: expected %b, got %b", e.overflow, ovf);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;

    checksum_scoreboard sb = new();

    tphc_in_if  seg_if();
    tphc_out_if res_if();

    transport_pseudo_header_checksum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_seg       (seg_if),
        .o_res       (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check accepted beats, then decide ready for the next edge
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                sb.compare_result(res_if.checksum_value, res_if.segment_length,
                                  res_if.length_overflow);
            if (hold_off_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                res_if.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready) ||
                cfg_wr_en || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("transport_pseudo_header_checksum_core_test NOT OK");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic fin);
        while (int'($urandom_range(99)) < sender_idle_pct) begin
            seg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_if.valid        <= 1'b1;
        seg_if.segment_byte <= b;
        seg_if.final_byte   <= fin;
        do @(posedge i_clk); while (seg_if.ready !== 1'b1);
        sb.take_byte(b, fin);
    endtask

    task automatic send_segment(input int len);
        for (int i = 0; i < len; i++)
            send_beat(8'($urandom), i == len - 1);
    endtask

    task automatic wait_idle();
        seg_if.valid <= 1'b0;
        while (sb.pending_checksums.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] mode_word, input logic [31:0] src,
                                input logic [31:0] dst, input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [31:0]          val[4];
        int                   n;
        wait_idle();
        idx[0] = REG_PROTOCOL_MODE;       val[0] = mode_word;
        idx[1] = REG_SOURCE_ADDRESS;      val[1] = src;
        idx[2] = REG_DESTINATION_ADDRESS; val[2] = dst;
        idx[3] = REG_UNUSED;              val[3] = $urandom;
        n = poke_unused ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge i_clk);
            sb.set_reg(idx[k], val[k]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_address();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly short segments (1 to 24 bytes), now and then a longer one (25 to 96 bytes)
    function automatic int pick_length();
        if ($urandom_range(9) < 7)
            return $urandom_range(24, 1);
        return $urandom_range(96, 25);
    endfunction

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                             input bit squeeze);
        int sent;
        int len;
        sent            = 0;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        if (squeeze)
            hold_off_cycles = PRESSURE_CYCLES;
        while (sent < items) begin
            if ($urandom_range(7) == 0 && hold_off_cycles == 0)
                program_regs($urandom, pick_address(), pick_address(), 1'b0);
            len = pick_length();
            send_segment(len);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        seg_if.valid        <= 1'b0;
        seg_if.segment_byte <= '0;
        seg_if.final_byte   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte segment with reset registers
        send_beat(8'hff, 1'b1);
        // all-ones udp segment and addresses
        program_regs({30'd0, MODE_UDP}, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        repeat (7) send_beat(8'hff, 1'b0);
        send_beat(8'hff, 1'b1);
        // icmp, odd length, field at offset two
        program_regs({30'h3fff_ffff, MODE_ICMP}, 32'h0, 32'h0, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h5a, 1'b1);
        // spare mode behaves as icmp; unused register index poked too
        program_regs({30'($urandom), MODE_SPARE}, $urandom, $urandom, 1'b1);
        send_segment(4);
        program_regs({30'($urandom), MODE_TCP}, $urandom, $urandom, 1'b0);
        send_segment(5);

        run_phase(350, 0, 0, 1'b1);
        run_phase(300, 57, 0, 1'b0);
        run_phase(300, 0, 57, 1'b0);
        run_phase(300, 10, 10, 1'b0);
        wait_idle();

        if (sb.errors == 0)
            $display("transport_pseudo_header_checksum_core_test OK");
        else
            $display("transport_pseudo_header_checksum_core_test NOT OK");
        $finish;
    end

endmodule
